/* hw/rtl/pbl_pkg.sv */
package pbl_pkg;

   localparam int NUM_LEDS_DEFAULT = 8;

   localparam int LIT_W  = 3;
   localparam int POS_W  = 4;
   localparam int CNT_W  = 4;
   localparam int PAT_W  = 8;
   localparam int PCT_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CNT_W-1:0] DUTY_LIMIT = 4'd14;
   localparam logic [PAT_W-1:0] ALL_OFF    = 8'hFF;

   localparam logic [CNT_W-1:0] RAMP_PERIODS_RESET = 4'd5;
   localparam logic [CNT_W-1:0] DUTY_TOP_RESET     = 4'd10;
   localparam logic [PAT_W-1:0] IDLE_PATTERN_RESET = 8'hE7;

   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_PERIODS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_TOP     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_PATTERN = 2'd2;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'b001,
      MODE_FORWARD = 3'b010,
      MODE_REVERSE = 3'b100
   } mode_type;

   typedef struct packed {
      logic [CNT_W-1:0] ramp_periods;
      logic [CNT_W-1:0] duty_top;
      logic [PAT_W-1:0] idle_pattern;
   } cfg_type;

   typedef struct packed {
      logic [PCT_W-1:0] duty_percent;
      logic [POS_W-1:0] led_position;
      logic [PAT_W-1:0] led_pattern;
   } result_type;

endpackage

/* hw/rtl/pbl_engine.sv */
module pbl_engine
   import pbl_pkg::*;
#(
   parameter int NUM_LEDS = NUM_LEDS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic       action,
   input  logic       hold,
   input  cfg_type    cfg,
   output result_type result
);

   localparam logic [POS_W-1:0] LED_COUNT = POS_W'(NUM_LEDS);
   localparam logic [LIT_W-1:0] LAST_LED  = LIT_W'(NUM_LEDS - 1);

   logic [CNT_W-1:0] phase_ff, phase_in;
   logic [CNT_W-1:0] duty_ff, duty_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             falling_ff, falling_in;
   mode_type         mode_ff, mode_in;
   logic [LIT_W-1:0] lit_ff, lit_in;
   logic [PAT_W-1:0] pattern_ff, pattern_in;

   logic [CNT_W-1:0] top;
   logic [CNT_W-1:0] phase_inc;
   logic [CNT_W-1:0] count_inc;
   logic [CNT_W-1:0] duty_inc;
   logic [POS_W-1:0] lit_wide_inc;
   logic [PAT_W-1:0] lit_drive;
   logic [LIT_W-1:0] lit_moved;

   always_comb begin
      top          = (cfg.duty_top > DUTY_LIMIT) ? DUTY_LIMIT : cfg.duty_top;
      phase_inc    = phase_ff + 1'b1;
      count_inc    = count_ff + 1'b1;
      duty_inc     = duty_ff + 1'b1;
      lit_wide_inc = {1'b0, lit_ff} + 1'b1;
      lit_drive    = ~(PAT_W'(1) << lit_ff);

      unique case (mode_ff)
         MODE_FORWARD: lit_moved = (lit_wide_inc >= LED_COUNT) ? '0 : lit_wide_inc[LIT_W-1:0];
         MODE_REVERSE: begin
            if (lit_ff == '0 || {1'b0, lit_ff} >= LED_COUNT) begin
               lit_moved = LAST_LED;
            end else begin
               lit_moved = lit_ff - 1'b1;
            end
         end
         default:      lit_moved = lit_ff;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      duty_in    = duty_ff;
      count_in   = count_ff;
      falling_in = falling_ff;
      mode_in    = mode_ff;
      lit_in     = lit_ff;
      pattern_in = pattern_ff;

      if (action) begin
         unique case (mode_ff)
            MODE_IDLE:    mode_in = MODE_FORWARD;
            MODE_FORWARD: mode_in = MODE_REVERSE;
            default:      mode_in = MODE_FORWARD;
         endcase
      end else if (mode_ff == MODE_IDLE) begin
         pattern_in = cfg.idle_pattern;
      end else if (phase_inc <= duty_ff) begin
         phase_in   = phase_inc;
         pattern_in = lit_drive;
      end else if (phase_inc <= top) begin
         phase_in   = phase_inc;
         pattern_in = ALL_OFF;
      end else begin
         // end of a pwm period
         phase_in   = '0;
         pattern_in = lit_drive;
         if (!hold) begin
            if (count_inc >= cfg.ramp_periods) begin
               count_in = '0;
               if (!falling_ff) begin
                  if (duty_inc > top || duty_inc == '0) begin
                     duty_in    = top;
                     falling_in = 1'b1;
                  end else begin
                     duty_in = duty_inc;
                  end
               end else if (duty_ff == '0) begin
                  falling_in = 1'b0;
                  lit_in     = lit_moved;
               end else begin
                  duty_in = duty_ff - 1'b1;
               end
            end else begin
               count_in = count_inc;
            end
         end
      end
   end

   always_comb begin
      result.led_pattern  = pattern_in;
      result.led_position = {1'b0, lit_in} + 1'b1;
      result.duty_percent = {1'b0, duty_in, 3'b000} + {3'b000, duty_in, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         duty_ff    <= '0;
         count_ff   <= '0;
         falling_ff <= 1'b0;
         mode_ff    <= MODE_IDLE;
         lit_ff     <= '0;
         pattern_ff <= ALL_OFF;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         duty_ff    <= duty_in;
         count_ff   <= count_in;
         falling_ff <= falling_in;
         mode_ff    <= mode_in;
         lit_ff     <= lit_in;
         pattern_ff <= pattern_in;
      end
   end

endmodule

/* hw/rtl/pwm_breathing_led_chaser.sv */
// Breathing LED chaser for a row of active-low LEDs.
// Request channel (req_): one transaction is either a timer tick (req_tuser = 0)
// or a direction key release (req_tuser = 1); req_tdata[0] is the hold flag that
// freezes the brightness ramp while the pwm keeps running.
// Response channel (rsp_): exactly one transaction per request, carrying the
// led drive pattern, the one-based position of the breathing led and the duty
// level times ten.
// Configuration: csr_we writes csr_wdata into the register picked by csr_index
// (0 ramp periods, 1 duty top, 2 idle pattern); write only while the block is idle.
// Path: a request taken lands in the input register, and once the result register
// is free or its response is being taken, the result is registered there and
// raises rsp_tvalid.
// Throughput: one transaction per cycle while responses are taken; the state update
// is a single pass of compares and small adds between the two registers.
// Reset: synchronous; mode idle, leds off, registers at their default values.
// A stalled response holds its data; the input register still takes one more
// request, then req_tready drops until the response is taken.
module pwm_breathing_led_chaser
   import pbl_pkg::*;
#(
   parameter int NUM_LEDS = NUM_LEDS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] hold, [7:1] zero
   input  logic                  req_tuser,   // [0] action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [7:0] led_pattern, [11:8] led_position,
                                              // [19:12] duty_percent, [23:20] zero
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic       in_action_ff;
   logic       in_hold_ff;
   logic       out_valid_ff;
   result_type out_data_ff;
   result_type step_result;
   logic       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_periods <= RAMP_PERIODS_RESET;
         cfg_ff.duty_top     <= DUTY_TOP_RESET;
         cfg_ff.idle_pattern <= IDLE_PATTERN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RAMP_PERIODS: cfg_ff.ramp_periods <= csr_wdata[CNT_W-1:0];
            CSR_DUTY_TOP:     cfg_ff.duty_top     <= csr_wdata[CNT_W-1:0];
            CSR_IDLE_PATTERN: cfg_ff.idle_pattern <= csr_wdata[PAT_W-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_action_ff <= req_tuser;
         in_hold_ff   <= req_tdata[0];
      end
   end

   pbl_engine #(
      .NUM_LEDS(NUM_LEDS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .action  (in_action_ff),
      .hold    (in_hold_ff),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   // led position stays within the row
   a_position_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.led_position >= POS_W'(1) &&
                        out_data_ff.led_position <= POS_W'(NUM_LEDS)))
      else $error("led position out of range");

   // duty percent never exceeds ten times DUTY_LIMIT
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_data_ff.duty_percent <= PCT_W'(140))
      else $error("duty percent out of range");

   // a request waiting on a stalled response is kept
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("pending request lost");

   // a new response only replaces a taken one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !advance)
      else $error("stalled response overwritten");

endmodule

/* tb/chaser_checker.sv */
module chaser_checker
   import pbl_pkg::*;
#(
   parameter int NUM_LEDS = NUM_LEDS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] hold, [7:1] zero
   input  logic                  req_tuser,   // [0] action
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [23:0]           rsp_tdata,   // [7:0] led_pattern, [11:8] led_position,
                                              // [19:12] duty_percent, [23:20] zero
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    results_pending
);

   logic [CNT_W-1:0] ramp_periods;
   logic [CNT_W-1:0] duty_top;
   logic [PAT_W-1:0] idle_pattern;

   logic [CNT_W-1:0] pwm_phase;
   logic [CNT_W-1:0] duty_level;
   logic [CNT_W-1:0] period_count;
   logic             falling;
   mode_type         run_mode;
   logic [LIT_W-1:0] lit_index;
   logic [PAT_W-1:0] driven_pattern;

   result_type expected_leds[$];

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 50) $display("mismatch at %0t: %s", $time, msg);
   endtask

   function automatic logic [PAT_W-1:0] lit_drive();
      logic [PAT_W-1:0] one_hot;
      one_hot = PAT_W'(1);
      return ~(one_hot << lit_index);
   endfunction

   // one request moves the chaser state; returns the expected response it leads to
   function automatic result_type advance_chaser(input logic key, input logic hold);
      logic [CNT_W-1:0] top;
      logic [PCT_W-1:0] level_wide;
      result_type r;
      top = (duty_top > DUTY_LIMIT) ? DUTY_LIMIT : duty_top;
      if (key) begin
         // idle and reverse go forward, forward goes reverse
         run_mode = (run_mode == MODE_FORWARD) ? MODE_REVERSE : MODE_FORWARD;
      end else if (run_mode == MODE_IDLE) begin
         driven_pattern = idle_pattern;
      end else begin
         pwm_phase = pwm_phase + 1'b1;
         if (pwm_phase <= duty_level) begin
            driven_pattern = lit_drive();
         end else if (pwm_phase <= top) begin
            driven_pattern = ALL_OFF;
         end else begin
            // end of a pwm period
            driven_pattern = lit_drive();
            pwm_phase = '0;
            if (!hold) begin
               period_count = period_count + 1'b1;
               if (period_count >= ramp_periods) begin
                  period_count = '0;
                  if (!falling) begin
                     duty_level = duty_level + 1'b1;
                     if (duty_level > top || duty_level == '0) begin
                        duty_level = top;
                        falling = 1'b1;
                     end
                  end else if (duty_level == '0) begin
                     falling = 1'b0;
                     if (run_mode == MODE_FORWARD) begin
                        lit_index = (int'(lit_index) + 1 >= NUM_LEDS) ? '0 : lit_index + 1'b1;
                     end else if (run_mode == MODE_REVERSE) begin
                        lit_index = (lit_index == '0 || int'(lit_index) >= NUM_LEDS) ?
                                    LIT_W'(NUM_LEDS - 1) : lit_index - 1'b1;
                     end
                  end else begin
                     duty_level = duty_level - 1'b1;
                  end
               end
            end
         end
      end
      level_wide = duty_level;
      r.led_pattern  = driven_pattern;
      r.led_position = {1'b0, lit_index} + 1'b1;
      r.duty_percent = level_wide * 8'd10;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         ramp_periods   = RAMP_PERIODS_RESET;
         duty_top       = DUTY_TOP_RESET;
         idle_pattern   = IDLE_PATTERN_RESET;
         pwm_phase      = '0;
         duty_level     = '0;
         period_count   = '0;
         falling        = 1'b0;
         run_mode       = MODE_IDLE;
         lit_index      = '0;
         driven_pattern = ALL_OFF;
         expected_leds.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RAMP_PERIODS: ramp_periods = csr_wdata[CNT_W-1:0];
               CSR_DUTY_TOP:     duty_top     = csr_wdata[CNT_W-1:0];
               CSR_IDLE_PATTERN: idle_pattern = csr_wdata[PAT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[19:0];
            if (expected_leds.size() == 0) begin
               note_mismatch($sformatf("response %h with no request pending", rsp_tdata));
            end else begin
               want = expected_leds.pop_front();
               if (got.led_pattern !== want.led_pattern)
                  note_mismatch($sformatf("led_pattern %h, want %h",
                                          got.led_pattern, want.led_pattern));
               if (got.led_position !== want.led_position)
                  note_mismatch($sformatf("led_position %0d, want %0d",
                                          got.led_position, want.led_position));
               if (got.duty_percent !== want.duty_percent)
                  note_mismatch($sformatf("duty_percent %0d, want %0d",
                                          got.duty_percent, want.duty_percent));
            end
         end
         if (req_tvalid && req_tready)
            expected_leds.push_back(advance_chaser(req_tuser, req_tdata[0]));
      end
      results_pending = expected_leds.size();
   end

endmodule

/* tb/tb_pwm_breathing_led_chaser.sv */
module tb_pwm_breathing_led_chaser;
   import pbl_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic TIMER_TICK  = 1'b0;
   localparam logic KEY_RELEASE = 1'b1;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int RANDOM_PHASES = 8;
   localparam int IDLE_SEGMENT  = 340;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatch_count;
   int results_pending;
   int items_sent = 0;
   int send_idle_pct = 18;
   int take_idle_pct = 49;

   always #4 clock = ~clock;

   pwm_breathing_led_chaser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   chaser_checker chaser_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= take_idle_pct);

   task automatic send_item(input logic action, input logic hold);
      if (items_sent >= 2 * IDLE_SEGMENT) begin
         send_idle_pct = 0;
         take_idle_pct = 0;
      end else if (items_sent >= IDLE_SEGMENT) begin
         send_idle_pct = 49;
         take_idle_pct = 18;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {7'b0, hold};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   // upper nibble of the 4-bit registers is junk the block must drop
   task automatic configure(input logic [CNT_W-1:0] ramp, input logic [CNT_W-1:0] top,
                            input logic [PAT_W-1:0] pattern);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_RAMP_PERIODS;
      csr_wdata <= {4'($urandom), ramp};
      @(posedge clock);
      csr_index <= CSR_DUTY_TOP;
      csr_wdata <= {4'($urandom), top};
      @(posedge clock);
      csr_index <= CSR_IDLE_PATTERN;
      csr_wdata <= pattern;
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= 8'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [CNT_W-1:0] ramp;
      logic [CNT_W-1:0] top;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // idle ticks show the programmed pattern, with and without hold
      send_item(TIMER_TICK, 1'b0);
      send_item(TIMER_TICK, 1'b1);
      configure(4'd15, 4'd15, 8'hFF);
      send_item(TIMER_TICK, 1'b1);
      // zero ramp periods and zero duty top: a move every second tick
      configure(4'd0, 4'd0, 8'h00);
      send_item(TIMER_TICK, 1'b0);
      send_item(KEY_RELEASE, 1'b1);
      repeat (4) send_item(TIMER_TICK, 1'b0);
      send_item(KEY_RELEASE, 1'b0);
      // reverse wraps from the first led to the last
      repeat (6) send_item(TIMER_TICK, 1'b0);
      send_item(KEY_RELEASE, 1'b0);
      configure(4'd15, 4'd15, 8'($urandom));
      send_item(TIMER_TICK, 1'b1);
      send_item(TIMER_TICK, 1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin ramp = 4'd1;  top = 4'd1;  end
            1: begin ramp = 4'd2;  top = 4'd14; end
            2: begin ramp = 4'd0;  top = 4'd15; end
            3: begin ramp = 4'd15; top = 4'd0;  end
            default: begin
               ramp = 4'($urandom_range(0, 3));
               top  = 4'($urandom_range(0, 5));
            end
         endcase
         // state carries over, so a lowered top or ramp meets old level and count
         configure(ramp, top, 8'($urandom));
         repeat (RANDOM_ITEMS / RANDOM_PHASES)
            send_item($urandom_range(29) == 0, $urandom_range(7) == 0);
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_pwm_breathing_led_chaser OK");
      end else begin
         $display("tb_pwm_breathing_led_chaser NOT OK");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb_pwm_breathing_led_chaser NOT OK");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/pbl_pkg.sv
hw/rtl/pbl_engine.sv
hw/rtl/pwm_breathing_led_chaser.sv
tb/chaser_checker.sv
tb/tb_pwm_breathing_led_chaser.sv
